// ===== design/lpt_pkg.sv =====
// Shared types and constants of the lexeme position tokenizer.
// Used by lpt_parser, lexeme_position_tokenizer_top and lpt_checker; no dependencies.
package lpt_pkg;

  localparam logic [2:0] K_BYTE  = 3'd0;
  localparam logic [2:0] K_ENTRY = 3'd1;
  localparam logic [2:0] K_END   = 3'd2;
  localparam logic [2:0] K_ERROR = 3'd3;
  localparam logic [2:0] K_EOI   = 3'd4;

  localparam logic [1:0] E_SYNTAX   = 2'd0;
  localparam logic [1:0] E_NOESCAPE = 2'd1;
  localparam logic [1:0] E_ZEROPOS  = 2'd2;

  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_QUOTE  = 8'h27;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_BSLASH = 8'h5C;

  localparam int OUT_DATA_W = 32;

  typedef struct packed {
    logic [2:0]  kind;
    logic [7:0]  word_byte;
    logic [13:0] position;
    logic [1:0]  weight;
    logic [1:0]  error_code;
  } lpt_res_t;

  typedef struct packed {
    logic [1:0]           cnt;
    lpt_res_t [2:0]       res;
  } lpt_step_t;

endpackage

// ===== design/lexeme_position_tokenizer_top.sv =====
// Top level of the lexeme position tokenizer: input register, parser and result buffer.
// Depends on lpt_pkg and lpt_parser.
// A byte's results pass the input register and the result buffer before being offered.
// Throughput: one byte per cycle while each byte gives at most one result and the output
// does not stall; a byte with more holds the three-entry buffer until they are taken, and
// the input register takes one more byte meanwhile. Synchronous active-low reset returns
// the parser to the start of a string and empties the input register and result buffer.
module lexeme_position_tokenizer_top #(
  parameter int POSITION_LIMIT = 16383
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] in_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [7:0] word_byte, [21:8] position, [23:22] weight,
                                  // [25:24] error_code, [31:26] zero
  output logic [2:0]  out_tuser,  // [2:0] kind
  output logic        out_tlast
);
  import lpt_pkg::*;

  logic            inv_r;
  logic [7:0]      byte_r;
  logic [1:0]      cnt_r;
  lpt_res_t [2:0]  buf_r;
  lpt_step_t       step;
  logic            adv;
  logic            in_acc;
  logic            out_acc;

  assign adv       = inv_r && ((cnt_r == 2'd0) || (cnt_r == 2'd1 && out_tready));
  assign in_tready = !inv_r || adv;
  assign in_acc    = in_tvalid && in_tready;
  assign out_tvalid = (cnt_r != 2'd0);
  assign out_acc   = out_tvalid && out_tready;

  lpt_parser #(
    .POSITION_LIMIT(POSITION_LIMIT)
  ) u_parser (
    .clk    (clk),
    .rst_n  (rst_n),
    .byte_i (byte_r),
    .step_en(adv),
    .step_o (step)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inv_r <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (in_acc) begin
        inv_r <= 1'b1;
      end else if (adv) begin
        inv_r <= 1'b0;
      end
      if (adv) begin
        cnt_r <= step.cnt;
      end else if (out_acc) begin
        cnt_r <= cnt_r - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      byte_r <= in_tdata;
    end
    if (adv) begin
      buf_r <= step.res;
    end else if (out_acc) begin
      buf_r[0] <= buf_r[1];
      buf_r[1] <= buf_r[2];
    end
  end

  assign out_tuser = buf_r[0].kind;
  assign out_tdata = {(OUT_DATA_W - 26)'(0), buf_r[0].error_code, buf_r[0].weight,
                      buf_r[0].position, buf_r[0].word_byte};
  assign out_tlast = (cnt_r == 2'd1);

endmodule

// ===== design/lpt_parser.sv =====
// Parser state machine of the lexeme position tokenizer: holds the parse state and
// computes the results of one byte. Depends on lpt_pkg.
module lpt_parser #(
  parameter int POSITION_LIMIT = 16383
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [7:0]        byte_i,
  input  logic              step_en,
  output lpt_pkg::lpt_step_t step_o
);
  import lpt_pkg::*;

  localparam int PW = $clog2(POSITION_LIMIT + 1);

  typedef enum logic [2:0] {
    PH_WAIT, PH_WORD, PH_ESCAPE, PH_QUOTE, PH_AFTERQ, PH_POSSTART, PH_POSDELIM, PH_DISCARD
  } phase_t;

  phase_t        ph_r, ph_nxt;
  logic          esc_ret_r, esc_ret_nxt;
  logic          nonempty_r, nonempty_nxt;
  logic [PW-1:0] val_r, val_nxt;
  logic [1:0]    wgt_r, wgt_nxt;
  logic          dig_r, dig_nxt;
  logic          ent_r, ent_nxt;

  logic          is_sp, is_dg, is_letter;
  logic [3:0]    digit;
  logic [PW+3:0] prod;
  logic [PW-1:0] val_sat;
  logic [PW+13:0] pos_ext;
  logic [1:0]    letter_w;

  function automatic lpt_res_t mk(logic [2:0] k, logic [7:0] b, logic [13:0] p,
                                  logic [1:0] w, logic [1:0] e);
    lpt_res_t r;
    r.kind       = k;
    r.word_byte  = b;
    r.position   = p;
    r.weight     = w;
    r.error_code = e;
    return r;
  endfunction

  assign is_sp  = (byte_i == CH_SPACE) || (byte_i >= 8'd9 && byte_i <= 8'd13);
  assign is_dg  = (byte_i >= CH_ZERO) && (byte_i <= CH_NINE);
  assign digit  = 4'(byte_i - CH_ZERO);
  assign prod   = ({4'b0, val_r} << 3) + ({4'b0, val_r} << 1) + {{PW{1'b0}}, digit};
  assign val_sat = (prod > (PW+4)'(POSITION_LIMIT)) ? PW'(POSITION_LIMIT) : prod[PW-1:0];
  assign pos_ext = {14'b0, val_r};

  // Letters a..d and A..D share their low three bits 1..4, which map to weights 3..0.
  assign is_letter = (byte_i >= 8'h61 && byte_i <= 8'h64) ||
                     (byte_i >= 8'h41 && byte_i <= 8'h44) || (byte_i == CH_STAR);
  assign letter_w  = (byte_i == CH_STAR) ? 2'd3 : 2'(3'd4 - byte_i[2:0]);

  always_comb begin
    logic [1:0] n;
    logic       do_wait;
    logic       failed;
    n            = 2'd0;
    do_wait      = 1'b0;
    failed       = 1'b0;
    ph_nxt       = ph_r;
    esc_ret_nxt  = esc_ret_r;
    nonempty_nxt = nonempty_r;
    val_nxt      = val_r;
    wgt_nxt      = wgt_r;
    dig_nxt      = dig_r;
    ent_nxt      = ent_r;
    step_o.res   = '0;

    unique case (ph_r)
      PH_WAIT: begin
        do_wait = 1'b1;
      end
      PH_WORD: begin
        if (byte_i == CH_BSLASH) begin
          esc_ret_nxt = 1'b0;
          ph_nxt      = PH_ESCAPE;
        end else if (byte_i == CH_NUL || is_sp) begin
          step_o.res[n] = mk(K_END, 8'd0, 14'd0, 2'd0, 2'd0);
          n = n + 2'd1;
          ph_nxt = PH_WAIT;
          if (byte_i == CH_NUL) begin
            step_o.res[n] = mk(K_EOI, 8'd0, 14'd0, 2'd0, 2'd0);
            n = n + 2'd1;
          end
        end else if (byte_i == CH_COLON) begin
          ph_nxt = PH_POSSTART;
        end else begin
          step_o.res[n] = mk(K_BYTE, byte_i, 14'd0, 2'd0, 2'd0);
          n = n + 2'd1;
        end
      end
      PH_ESCAPE: begin
        if (byte_i == CH_NUL) begin
          step_o.res[n] = mk(K_ERROR, 8'd0, 14'd0, 2'd0, E_NOESCAPE);
          n = n + 2'd1;
          ent_nxt = 1'b0;
          dig_nxt = 1'b0;
          ph_nxt  = PH_WAIT;
        end else begin
          step_o.res[n] = mk(K_BYTE, byte_i, 14'd0, 2'd0, 2'd0);
          n = n + 2'd1;
          nonempty_nxt = 1'b1;
          ph_nxt = esc_ret_r ? PH_QUOTE : PH_WORD;
        end
      end
      PH_QUOTE: begin
        if (byte_i == CH_QUOTE) begin
          ph_nxt = PH_AFTERQ;
        end else if (byte_i == CH_BSLASH) begin
          esc_ret_nxt = 1'b1;
          ph_nxt      = PH_ESCAPE;
        end else if (byte_i == CH_NUL) begin
          failed = 1'b1;
          step_o.res[n] = mk(K_ERROR, 8'd0, 14'd0, 2'd0, E_SYNTAX);
          n = n + 2'd1;
        end else begin
          step_o.res[n] = mk(K_BYTE, byte_i, 14'd0, 2'd0, 2'd0);
          n = n + 2'd1;
          nonempty_nxt = 1'b1;
        end
      end
      PH_AFTERQ: begin
        if (byte_i == CH_QUOTE) begin
          step_o.res[n] = mk(K_BYTE, byte_i, 14'd0, 2'd0, 2'd0);
          n = n + 2'd1;
          nonempty_nxt = 1'b1;
          ph_nxt = PH_QUOTE;
        end else if (!nonempty_r) begin
          failed = 1'b1;
          step_o.res[n] = mk(K_ERROR, 8'd0, 14'd0, 2'd0, E_SYNTAX);
          n = n + 2'd1;
        end else if (byte_i == CH_COLON) begin
          ph_nxt = PH_POSSTART;
        end else begin
          step_o.res[n] = mk(K_END, 8'd0, 14'd0, 2'd0, 2'd0);
          n = n + 2'd1;
          ph_nxt  = PH_WAIT;
          do_wait = 1'b1;
        end
      end
      PH_POSSTART: begin
        if (is_dg) begin
          val_nxt = {{(PW-4){1'b0}}, digit};
          wgt_nxt = 2'd0;
          dig_nxt = 1'b1;
          ent_nxt = 1'b1;
          ph_nxt  = PH_POSDELIM;
        end else begin
          failed = 1'b1;
          step_o.res[n] = mk(K_ERROR, 8'd0, 14'd0, 2'd0, E_SYNTAX);
          n = n + 2'd1;
        end
      end
      PH_POSDELIM: begin
        if (dig_r && is_dg) begin
          val_nxt = val_sat;
        end else begin
          if (dig_r) begin
            dig_nxt = 1'b0;
            if (val_r == '0) begin
              failed = 1'b1;
              step_o.res[n] = mk(K_ERROR, 8'd0, 14'd0, 2'd0, E_ZEROPOS);
              n = n + 2'd1;
            end
          end
          if (!failed) begin
            if (byte_i == CH_COMMA) begin
              if (ent_r) begin
                step_o.res[n] = mk(K_ENTRY, 8'd0, pos_ext[13:0], wgt_r, 2'd0);
                n = n + 2'd1;
              end
              ent_nxt = 1'b0;
              ph_nxt  = PH_POSSTART;
            end else if (is_letter) begin
              if (wgt_r != 2'd0) begin
                failed = 1'b1;
                step_o.res[n] = mk(K_ERROR, 8'd0, 14'd0, 2'd0, E_SYNTAX);
                n = n + 2'd1;
              end else begin
                wgt_nxt = letter_w;
              end
            end else if (byte_i == CH_NUL || is_sp) begin
              if (ent_r) begin
                step_o.res[n] = mk(K_ENTRY, 8'd0, pos_ext[13:0], wgt_r, 2'd0);
                n = n + 2'd1;
              end
              ent_nxt = 1'b0;
              step_o.res[n] = mk(K_END, 8'd0, 14'd0, 2'd0, 2'd0);
              n = n + 2'd1;
              ph_nxt = PH_WAIT;
              if (byte_i == CH_NUL) begin
                step_o.res[n] = mk(K_EOI, 8'd0, 14'd0, 2'd0, 2'd0);
                n = n + 2'd1;
              end
            end else if (!is_dg) begin
              failed = 1'b1;
              step_o.res[n] = mk(K_ERROR, 8'd0, 14'd0, 2'd0, E_SYNTAX);
              n = n + 2'd1;
            end
          end
        end
      end
      PH_DISCARD: begin
        if (byte_i == CH_NUL) begin
          ph_nxt = PH_WAIT;
        end
      end
      default: begin
        ph_nxt = PH_WAIT;
      end
    endcase

    if (failed) begin
      ent_nxt = 1'b0;
      dig_nxt = 1'b0;
      ph_nxt  = (byte_i == CH_NUL) ? PH_WAIT : PH_DISCARD;
    end

    if (do_wait) begin
      if (byte_i == CH_NUL) begin
        step_o.res[n] = mk(K_EOI, 8'd0, 14'd0, 2'd0, 2'd0);
        n = n + 2'd1;
      end else if (byte_i == CH_QUOTE) begin
        nonempty_nxt = 1'b0;
        ph_nxt       = PH_QUOTE;
      end else if (byte_i == CH_BSLASH) begin
        esc_ret_nxt = 1'b0;
        ph_nxt      = PH_ESCAPE;
      end else if (!is_sp) begin
        step_o.res[n] = mk(K_BYTE, byte_i, 14'd0, 2'd0, 2'd0);
        n = n + 2'd1;
        ph_nxt = PH_WORD;
      end
    end

    step_o.cnt = n;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r       <= PH_WAIT;
      esc_ret_r  <= 1'b0;
      nonempty_r <= 1'b0;
      val_r      <= '0;
      wgt_r      <= 2'd0;
      dig_r      <= 1'b0;
      ent_r      <= 1'b0;
    end else if (step_en) begin
      ph_r       <= ph_nxt;
      esc_ret_r  <= esc_ret_nxt;
      nonempty_r <= nonempty_nxt;
      val_r      <= val_nxt;
      wgt_r      <= wgt_nxt;
      dig_r      <= dig_nxt;
      ent_r      <= ent_nxt;
    end
  end

endmodule

// ===== design/lpt_checker.sv =====
// Port-level checker of the lexeme position tokenizer, bound to the top level.
// Depends on lpt_pkg and lexeme_position_tokenizer_top.
module lpt_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic [7:0]  in_tdata,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [31:0] out_tdata,
  input logic [2:0]  out_tuser,
  input logic        out_tlast
);
  import lpt_pkg::*;

  logic in_seen;
  assign in_seen = in_tvalid && in_tready && (in_tdata == in_tdata);

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) &&
    $stable(out_tuser) && $stable(out_tlast))
    else $error("stalled result transaction changed");

  a_eoi_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == K_EOI || out_tuser == K_ERROR) |-> out_tlast)
    else $error("end of input or error is not the final result of its byte");

  a_byte_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == K_BYTE |-> out_tdata[31:8] == 24'd0)
    else $error("word byte result carries stray fields");

  a_error_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == K_ERROR |-> out_tdata[25:24] != 2'd3 &&
    out_tdata[23:0] == 24'd0)
    else $error("malformed error result");

  a_kind_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid || in_seen |-> out_tuser <= K_EOI || !out_tvalid)
    else $error("result kind out of range");

endmodule

bind lexeme_position_tokenizer_top lpt_checker u_lpt_checker (.*);
